/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: property does not hold");

// If the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/laq_pkg.sv */
// ----------------------------------------------------------------------------
// laq_pkg
// Types and constants shared by the linear array queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package laq_pkg;

    localparam int DEPTH_DEF       = 1024;
    localparam int ENTRY_WIDTH_DEF = 32;

    // Stream payload widths.
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 11;

    // Operation codes carried in the input tuser.
    localparam logic [IN_USER_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [IN_USER_W-1:0] OP_POP    = 2'd1;
    localparam logic [IN_USER_W-1:0] OP_STATUS = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_e_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic read;
        logic load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
    } stat_t;

endpackage

/* hdl/laq_ctrl.sv */
// ----------------------------------------------------------------------------
// laq_ctrl
// Sequencer: takes one transfer, waits for the front read, loads the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module laq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           m_tready,
    input  laq_pkg::stat_t stat,
    output laq_pkg::cmd_t  cmd
);
    import laq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.read    = 1'b0;
        cmd.load    = 1'b0;
        s_tready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // The output register frees up when its transfer completes.
                if (!stat.out_valid || m_tready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/laq_dpath.sv */
// ----------------------------------------------------------------------------
// laq_dpath
// Counters, slot memory, front, back and status registers, and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module laq_dpath #(
    parameter int DEPTH       = laq_pkg::DEPTH_DEF,
    parameter int ENTRY_WIDTH = laq_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  laq_pkg::cmd_t                cmd,
    output laq_pkg::stat_t               stat,
    input  logic [laq_pkg::IN_USER_W-1:0] op,
    input  logic [laq_pkg::IN_DATA_W-1:0] entry_value,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [laq_pkg::OUT_DATA_W-1:0] m_tdata
);
    import laq_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    logic [CNT_W-1:0]       pushed_reg;
    logic [CNT_W-1:0]       popped_reg;
    logic [ENTRY_WIDTH-1:0] back_reg;
    logic [ENTRY_WIDTH-1:0] front_reg;
    status_e_t              status_reg;
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;

    logic [ENTRY_WIDTH-1:0] slot_mem [DEPTH];

    logic [ENTRY_WIDTH+VALUE_W-1:0] value_wide;
    logic [ENTRY_WIDTH-1:0]         value_kept;
    logic                           is_full;
    logic                           is_empty;
    logic                           push_ok;
    logic                           pop_ok;
    logic [CNT_W-1:0]               diff;
    logic [CNT_W+COUNT_W-1:0]       diff_wide;
    logic [ENTRY_WIDTH+VALUE_W-1:0] front_wide;
    logic [ENTRY_WIDTH+VALUE_W-1:0] back_wide;
    logic [VALUE_W-1:0]             front_out;
    logic [VALUE_W-1:0]             back_out;

    assign value_wide = {{ENTRY_WIDTH{1'b0}}, entry_value};
    assign value_kept = value_wide[ENTRY_WIDTH-1:0];

    assign is_full  = (pushed_reg == CNT_W'(DEPTH));
    assign is_empty = (popped_reg == pushed_reg);
    assign push_ok  = cmd.capture && (op == OP_PUSH) && !is_full;
    assign pop_ok   = cmd.capture && (op == OP_POP) && !is_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pushed_reg <= '0;
            popped_reg <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                pushed_reg <= pushed_reg + 1'b1;
            end
            if (pop_ok)
            begin
                popped_reg <= popped_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            status_reg <= ST_DONE;
            case (op)
                OP_PUSH:
                begin
                    if (is_full)
                    begin
                        status_reg <= ST_FULL;
                    end
                end
                OP_POP:
                begin
                    if (is_empty)
                    begin
                        status_reg <= ST_EMPTY;
                    end
                end
                default:
                begin
                    status_reg <= ST_DONE;
                end
            endcase
        end
        if (push_ok)
        begin
            back_reg <= value_kept;
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slot_mem[pushed_reg[ADDR_W-1:0]] <= value_kept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            front_reg <= slot_mem[popped_reg[ADDR_W-1:0]];
        end
    end

    assign diff       = pushed_reg - popped_reg;
    assign diff_wide  = {{COUNT_W{1'b0}}, diff};
    assign front_wide = {{VALUE_W{1'b0}}, front_reg};
    assign back_wide  = {{VALUE_W{1'b0}}, back_reg};
    assign front_out  = is_empty ? '0 : front_wide[VALUE_W-1:0];
    assign back_out   = is_empty ? '0 : back_wide[VALUE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_data_reg <= {1'b0, is_full, is_empty, diff_wide[COUNT_W-1:0],
                             back_out, front_out, status_reg};
        end
    end

    assign stat.out_valid = out_valid_reg;
    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = out_data_reg;

endmodule

/* hdl/linear_array_queue_core.sv */
// Each item passes in turn through capture, the registered read of the front
// slot, and the load of the output register; the next input transfer is taken
// only once the item is back in idle. A waiting result does not block the next
// input transfer, but that item then holds in its load state, so input stalls
// until the waiting result is taken. Reset clears the push and pop counters and
// the output valid; slot memory needs no clearing pass.
`timescale 1ns / 1ps

`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// linear_array_queue_core
// Non-circular array queue: push, pop or status, one result per item.
// ----------------------------------------------------------------------------
module linear_array_queue_core #(
    parameter int DEPTH       = laq_pkg::DEPTH_DEF,
    parameter int ENTRY_WIDTH = laq_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] entry_value
    input  logic [laq_pkg::IN_DATA_W-1:0]  s_tdata,
    // [1:0] op
    input  logic [laq_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] status, [33:2] front_value, [65:34] back_value,
    // [76:66] entry_count, [77] is_empty, [78] is_full, [79] zero
    output logic [laq_pkg::OUT_DATA_W-1:0] m_tdata
);
    import laq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    laq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    laq_dpath #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .op          (s_tuser),
        .entry_value (s_tdata),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, !m_tvalid || (m_tdata[76:66] <= 11'(DEPTH)))
    `ASSERT_ALWAYS(a_empty_flag, clk, rst_n, !m_tvalid || (m_tdata[77] == (m_tdata[76:66] == 11'd0)))
    `ASSERT_ALWAYS(a_empty_zero, clk, rst_n, !m_tvalid || !m_tdata[77] || (m_tdata[65:2] == 64'd0))
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for linear_array_queue_core. Pushes, pops and status
// requests are sent over the input stream. A behavioral queue predicts the
// result of every accepted transfer, and each output transfer is compared
// field by field with the oldest prediction. Both sides idle at random. The
// run fills every slot once, so refused pushes are covered, and then drains
// the queue, so the case of a full queue that holds no entries is covered.
// ----------------------------------------------------------------------------
module tb_top;

    import laq_pkg::*;

    localparam int QUEUE_DEPTH = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 12;
    localparam int PRINT_LIMIT = 100;

    // The package leaves code 3 unnamed; the block treats it as a status request.
    localparam logic [IN_USER_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        status_e_t          status;
        logic [VALUE_W-1:0] front;
        logic [VALUE_W-1:0] back;
        logic [COUNT_W-1:0] count;
        logic               empty;
        logic               full;
    } queue_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Behavioral queue state.
    int unsigned        push_total;
    int unsigned        pop_total;
    logic [VALUE_W-1:0] slot_mem [QUEUE_DEPTH];

    queue_result_t results_pending[$];

    int  mismatch_cnt;
    int  result_cnt;
    int  random_sent;
    int  cycle_cnt;
    int  rx_hold_cycles;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;

    linear_array_queue_core #(
        .DEPTH       (QUEUE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH_DEF)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic queue_result_t predict_queue_step(input logic [IN_USER_W-1:0] op,
                                                         input logic [VALUE_W-1:0] value);
        queue_result_t r;
        r.status = ST_DONE;
        case (op)
            OP_PUSH:
            begin
                if (push_total >= QUEUE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    slot_mem[push_total] = value;
                    push_total++;
                end
            end
            OP_POP:
            begin
                if (pop_total >= push_total)
                    r.status = ST_EMPTY;
                else
                    pop_total++;
            end
            default:
            begin
            end
        endcase
        r.empty = (pop_total >= push_total);
        r.front = r.empty ? '0 : slot_mem[pop_total];
        r.back  = r.empty ? '0 : slot_mem[push_total - 1];
        r.count = r.empty ? '0 : COUNT_W'(push_total - pop_total);
        r.full  = (push_total >= QUEUE_DEPTH);
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] random_entry();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_LIMIT)
            $display("tb_top: result %0d, %s: got 0x%0h, expected 0x%0h",
                     result_cnt, field, got, want);
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] word);
        queue_result_t want;
        result_cnt++;
        if (results_pending.size() == 0)
            report_mismatch("transfer with no result pending", word[63:0], '0);
        else
        begin
            want = results_pending.pop_front();
            if (word[1:0] !== want.status)
                report_mismatch("status", word[1:0], want.status);
            if (word[33:2] !== want.front)
                report_mismatch("front_value", word[33:2], want.front);
            if (word[65:34] !== want.back)
                report_mismatch("back_value", word[65:34], want.back);
            if (word[76:66] !== want.count)
                report_mismatch("entry_count", word[76:66], want.count);
            if (word[77] !== want.empty)
                report_mismatch("is_empty", word[77], want.empty);
            if (word[78] !== want.full)
                report_mismatch("is_full", word[78], want.full);
            if (word[79] !== 1'b0)
                report_mismatch("pad bit", word[79], 1'b0);
        end
    endtask

    // Output side: a random stall before each transfer while idling is on, or a long hold on request.
    initial
    begin
        int stall;
        int held;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
                stall = rx_idle_on ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                held = 0;
                while (held < stall)
                begin
                    @(posedge clk);
                    held++;
                end
            end
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_tvalid);
            check_result(m_tdata);
        end
    end

    task automatic send_item(input logic [IN_USER_W-1:0] op, input logic [VALUE_W-1:0] value);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        results_pending.push_back(predict_queue_step(op, value));
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (results_pending.size() != 0);
    endtask

    task automatic send_random(input int push_pct, input int pop_pct);
        int pick;
        logic [IN_USER_W-1:0] op;
        random_sent++;
        if (random_sent % 64 == 0)
        begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
        end
        if ($urandom_range(0, 149) == 0)
            wait_all_results();
        pick = $urandom_range(0, 99);
        if (pick < push_pct)
            op = OP_PUSH;
        else if (pick < push_pct + pop_pct)
            op = OP_POP;
        else if (pick < 97)
            op = OP_STATUS;
        else
            op = OP_UNUSED;
        send_item(op, random_entry());
    endtask

    task automatic test_directed();
        send_item(OP_STATUS, 32'h0000_0000);
        send_item(OP_UNUSED, 32'hFFFF_FFFF);
        send_item(OP_POP,    32'h1234_5678);
        send_item(OP_PUSH,   32'h0000_0000);
        send_item(OP_PUSH,   32'hFFFF_FFFF);
        send_item(OP_STATUS, 32'hFFFF_FFFF);
        send_item(OP_PUSH,   32'h5555_AAAA);
        send_item(OP_PUSH,   32'hAAAA_5555);
        send_item(OP_UNUSED, 32'h0000_0000);
        send_item(OP_POP,    32'hFFFF_FFFF);
        send_item(OP_POP,    32'h0000_0000);
        send_item(OP_POP,    32'h0000_0000);
        send_item(OP_POP,    32'h0000_0000);
        send_item(OP_POP,    32'h0000_0000);
        send_item(OP_PUSH,   32'h8000_0001);
        send_item(OP_POP,    32'h0000_0000);
        send_item(OP_STATUS, 32'h0000_0000);
        wait_all_results();
    endtask

    // The output side holds off while items keep coming, so the input must stall.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_hold_cycles = 300;
        repeat (40) send_random(70, 20);
        wait_all_results();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_mixed_traffic();
        repeat (300) send_random(50, 40);
    endtask

    task automatic test_fill_to_full();
        while (push_total < QUEUE_DEPTH)
            send_random(92, 4);
        repeat (20) send_random(80, 5);
    endtask

    // Once every slot has been used, pushes stay refused even on an empty queue.
    task automatic test_drain_after_full();
        while (pop_total < push_total)
            send_random(12, 80);
        repeat (40) send_random(40, 40);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_mixed_traffic();
        test_fill_to_full();
        test_drain_after_full();
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
